// ===== design/crrc_pkg.sv =====
// shared types and codes for the clipped rectangle copy block
package crrc_pkg;

  localparam int RECT_W   = 10;  // signed rectangle coordinate registers
  localparam int SIZE_W   = 9;   // frame size registers
  localparam int CRD_W    = 12;  // signed working coordinate, holds source plus offset
  localparam int CRD_UW   = 9;   // unsigned coordinate inside the frame
  localparam int IDX_W    = 3;
  localparam int CFG_W    = 10;
  localparam int MODE_W   = 2;
  localparam int STAT_W   = 2;
  localparam int PIX_IO_W = 24;

  localparam logic [MODE_W-1:0] MODE_WRITE = 2'd0;
  localparam logic [MODE_W-1:0] MODE_READ  = 2'd1;
  localparam logic [MODE_W-1:0] MODE_COPY  = 2'd2;

  localparam logic [STAT_W-1:0] STAT_OK           = 2'd0;
  localparam logic [STAT_W-1:0] STAT_BAD_RECT     = 2'd1;
  localparam logic [STAT_W-1:0] STAT_OUT_OF_FRAME = 2'd2;

  localparam logic [IDX_W-1:0] REG_IMAGE_WIDTH  = 3'd0;
  localparam logic [IDX_W-1:0] REG_IMAGE_HEIGHT = 3'd1;
  localparam logic [IDX_W-1:0] REG_SRC_LEFT_X   = 3'd2;
  localparam logic [IDX_W-1:0] REG_SRC_TOP_Y    = 3'd3;
  localparam logic [IDX_W-1:0] REG_SRC_RIGHT_X  = 3'd4;
  localparam logic [IDX_W-1:0] REG_SRC_BOTTOM_Y = 3'd5;
  localparam logic [IDX_W-1:0] REG_DEST_LEFT_X  = 3'd6;
  localparam logic [IDX_W-1:0] REG_DEST_TOP_Y   = 3'd7;

  localparam logic [SIZE_W-1:0] RST_IMAGE_SIZE = 9'd256;
  localparam logic [RECT_W-1:0] RST_RECT_LO    = 10'd0;
  localparam logic [RECT_W-1:0] RST_RECT_HI    = 10'd1;

  typedef struct packed {
    logic signed [RECT_W-1:0] src_left_x;
    logic signed [RECT_W-1:0] src_top_y;
    logic signed [RECT_W-1:0] src_right_x;
    logic signed [RECT_W-1:0] src_bottom_y;
    logic signed [RECT_W-1:0] dest_left_x;
    logic signed [RECT_W-1:0] dest_top_y;
  } crrc_rect_t;

  typedef struct packed {
    logic              busy;
    logic              done;
    logic [STAT_W-1:0] status;
  } crrc_walk_res_t;

endpackage

// ===== design/crrc_frame_mem.sv =====
// frame memory: one write port, one read port with registered read data
module crrc_frame_mem #(
  parameter int DEPTH = 65536,
  parameter int AW    = 16,
  parameter int DW    = 24
) (
  input  logic          clk,
  input  logic          we,
  input  logic [AW-1:0] waddr,
  input  logic [DW-1:0] wdata,
  input  logic          re,
  input  logic [AW-1:0] raddr,
  output logic [DW-1:0] rdata
);

  logic [DW-1:0] mem [0:DEPTH-1];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
  end

  always_ff @(posedge clk) begin
    if (re) begin
      rdata <= mem[raddr];
    end
  end

endmodule

// ===== design/crrc_copy_walker.sv =====
// copy sequencer: clips the source rectangle and walks it, one source read per cycle
module crrc_copy_walker #(
  parameter int MAX_WIDTH = 256,
  parameter int AW        = 16
) (
  input  logic                          clk,
  input  logic                          rst,
  input  logic                          start,
  input  crrc_pkg::crrc_rect_t          rect,
  input  logic [crrc_pkg::SIZE_W-1:0]   used_w,
  input  logic [crrc_pkg::SIZE_W-1:0]   used_h,
  output logic                          rd_en,
  output logic [AW-1:0]                 rd_addr,
  output logic                          wr_en,
  output logic [AW-1:0]                 wr_addr,
  output crrc_pkg::crrc_walk_res_t      res
);
  import crrc_pkg::*;

  localparam logic [2:0] W_IDLE  = 3'd0;
  localparam logic [2:0] W_SETUP = 3'd1;
  localparam logic [2:0] W_PLAN  = 3'd2;
  localparam logic [2:0] W_RUN   = 3'd3;
  localparam logic [2:0] W_DRAIN = 3'd4;
  localparam logic [2:0] W_DONE  = 3'd5;

  logic [2:0]              wstate;
  logic                    wr_pend;
  logic [AW-1:0]           wr_addr_r;
  logic [STAT_W-1:0]       stat_r;
  logic signed [CRD_W-1:0] cx0, cx1, cy0, cy1;
  logic signed [CRD_W-1:0] off_x, off_y;
  logic signed [CRD_W-1:0] x_first, x_last, y_last;
  logic signed [CRD_W-1:0] sx, sy;
  logic                    rev_x, rev_y;

  logic signed [CRD_W-1:0] left, top, right, bottom, dleft, dtop;
  logic signed [CRD_W-1:0] wext, hext;
  logic signed [CRD_W-1:0] clip_x0, clip_x1, clip_y0, clip_y1;
  logic signed [CRD_W-1:0] dx, dy;
  logic                    bad_rect, in_frame;

  always_comb begin
    left     = CRD_W'($signed(rect.src_left_x));
    top      = CRD_W'($signed(rect.src_top_y));
    right    = CRD_W'($signed(rect.src_right_x));
    bottom   = CRD_W'($signed(rect.src_bottom_y));
    dleft    = CRD_W'($signed(rect.dest_left_x));
    dtop     = CRD_W'($signed(rect.dest_top_y));
    wext     = $signed({{(CRD_W-SIZE_W){1'b0}}, used_w});
    hext     = $signed({{(CRD_W-SIZE_W){1'b0}}, used_h});
    bad_rect = (left >= right) || (top >= bottom);
    clip_x0  = (left < 0) ? '0 : left;
    clip_y0  = (top < 0) ? '0 : top;
    clip_x1  = (right < wext) ? right : wext;
    clip_y1  = (bottom < hext) ? bottom : hext;
    dx       = sx + off_x;
    dy       = sy + off_y;
    in_frame = (dx >= 0) && (dx < wext) && (dy >= 0) && (dy < hext);
  end

  assign rd_en   = (wstate == W_RUN);
  assign rd_addr = AW'(AW'(sy[CRD_UW-1:0]) * AW'(MAX_WIDTH) + AW'(sx[CRD_UW-1:0]));
  assign wr_en   = wr_pend;
  assign wr_addr = wr_addr_r;

  assign res.busy   = (wstate != W_IDLE);
  assign res.done   = (wstate == W_DONE);
  assign res.status = stat_r;

  always_ff @(posedge clk) begin
    if (rst) begin
      wstate  <= W_IDLE;
      wr_pend <= 1'b0;
    end else begin
      wr_pend <= (wstate == W_RUN) && in_frame;
      case (wstate)
        W_IDLE: begin
          if (start) begin
            wstate <= W_SETUP;
          end
        end
        W_SETUP: begin
          wstate <= bad_rect ? W_DONE : W_PLAN;
        end
        W_PLAN: begin
          // a clip that leaves no area copies nothing
          if ((cx1 <= cx0) || (cy1 <= cy0)) begin
            wstate <= W_DONE;
          end else begin
            wstate <= W_RUN;
          end
        end
        W_RUN: begin
          if ((sx == x_last) && (sy == y_last)) begin
            wstate <= W_DRAIN;
          end
        end
        W_DRAIN: begin
          wstate <= W_DONE;
        end
        W_DONE: begin
          wstate <= W_IDLE;
        end
        default: begin
          wstate <= W_IDLE;
        end
      endcase
    end
  end

  // walk order follows the shift so that no source pixel is overwritten before it is read
  always_ff @(posedge clk) begin
    case (wstate)
      W_SETUP: begin
        stat_r <= bad_rect ? STAT_BAD_RECT : STAT_OK;
        cx0    <= clip_x0;
        cx1    <= clip_x1;
        cy0    <= clip_y0;
        cy1    <= clip_y1;
      end
      W_PLAN: begin
        off_x   <= dleft - cx0;
        off_y   <= dtop - cy0;
        rev_x   <= dleft > cx0;
        rev_y   <= dtop > cy0;
        x_first <= (dleft > cx0) ? CRD_W'(cx1 - 1) : cx0;
        x_last  <= (dleft > cx0) ? cx0 : CRD_W'(cx1 - 1);
        y_last  <= (dtop > cy0) ? cy0 : CRD_W'(cy1 - 1);
        sx      <= (dleft > cx0) ? CRD_W'(cx1 - 1) : cx0;
        sy      <= (dtop > cy0) ? CRD_W'(cy1 - 1) : cy0;
      end
      W_RUN: begin
        wr_addr_r <= AW'(AW'(dy[CRD_UW-1:0]) * AW'(MAX_WIDTH) + AW'(dx[CRD_UW-1:0]));
        if (sx == x_last) begin
          sx <= x_first;
          sy <= rev_y ? CRD_W'(sy - 1) : CRD_W'(sy + 1);
        end else begin
          sx <= rev_x ? CRD_W'(sx - 1) : CRD_W'(sx + 1);
        end
      end
      default: begin
      end
    endcase
  end

endmodule

// ===== design/clipped_rect_region_copy.sv =====
// top level: frame buffer with pixel access and clipped rectangle copy
// Frame buffer of MAX_WIDTH x MAX_HEIGHT pixels held in one simple dual-port memory, with
// no reset of its contents and no clearing pass: read only pixels that have been written.
// One item is handled at a time; the input is taken again as soon as the previous item has
// been moved to the output register, even if that result is still stalled. A pixel write,
// an unused mode or a pixel address outside the frame goes through the execute and response
// states; a pixel read inside the frame adds a read-wait state. A copy walks the cw x ch
// source rectangle left after clipping to the frame: the sequencer reads one source pixel
// per cycle through the memory's single read port and writes it to the destination in the
// next cycle. An invalid rectangle ends the copy in the setup state, an empty clip in the
// plan state. A stalled output holds the result in the response state. The walk order
// follows the direction of the shift, so an overlapping copy sees the frame as it stood
// before the copy. Configuration registers may only be written while no item is in progress.
module clipped_rect_region_copy #(
  parameter int MAX_WIDTH  = 256,
  parameter int MAX_HEIGHT = 256,
  parameter int PIXEL_BITS = 24
) (
  input  logic                            clk,
  input  logic                            rst,
  input  logic                            cfg_we,
  input  logic [crrc_pkg::IDX_W-1:0]      cfg_index,
  input  logic [crrc_pkg::CFG_W-1:0]      cfg_data,
  input  logic                            in_valid,
  output logic                            in_stall,
  input  logic [crrc_pkg::MODE_W-1:0]     mode,
  input  logic [7:0]                      pixel_x,
  input  logic [7:0]                      pixel_y,
  input  logic [crrc_pkg::PIX_IO_W-1:0]   pixel_in,
  output logic                            out_valid,
  input  logic                            out_stall,
  output logic [crrc_pkg::PIX_IO_W-1:0]   pixel_out,
  output logic [crrc_pkg::STAT_W-1:0]     status
);
  import crrc_pkg::*;

  localparam int DEPTH = MAX_WIDTH * MAX_HEIGHT;
  localparam int AW    = (DEPTH > 1) ? $clog2(DEPTH) : 1;

  localparam logic [2:0] S_IDLE   = 3'd0;
  localparam logic [2:0] S_EXEC   = 3'd1;
  localparam logic [2:0] S_RDWAIT = 3'd2;
  localparam logic [2:0] S_COPY   = 3'd3;
  localparam logic [2:0] S_RESP   = 3'd4;

  logic [2:0]             state;
  logic [SIZE_W-1:0]      image_width, image_height;
  crrc_rect_t             rect;
  logic [SIZE_W-1:0]      used_w, used_h;

  logic [MODE_W-1:0]      mode_r;
  logic [7:0]             x_r, y_r;
  logic [PIXEL_BITS-1:0]  val_r;
  logic [PIX_IO_W-1:0]    res_pix;
  logic [STAT_W-1:0]      res_stat;

  logic                   in_range, accept, out_free;
  logic [AW-1:0]          pix_addr;

  logic                   mem_we, mem_re;
  logic [AW-1:0]          mem_waddr, mem_raddr;
  logic [PIXEL_BITS-1:0]  mem_wdata, mem_rdata;

  logic                   walk_start, walk_rd_en, walk_wr_en;
  logic [AW-1:0]          walk_rd_addr, walk_wr_addr;
  crrc_walk_res_t         walk_res;

  always_comb begin
    used_w   = (int'(image_width) < MAX_WIDTH) ? image_width : SIZE_W'(MAX_WIDTH);
    used_h   = (int'(image_height) < MAX_HEIGHT) ? image_height : SIZE_W'(MAX_HEIGHT);
    in_range = ({1'b0, x_r} < used_w) && ({1'b0, y_r} < used_h);
    pix_addr = AW'(AW'(y_r) * AW'(MAX_WIDTH) + AW'(x_r));
    accept   = in_valid && !in_stall;
    out_free = !out_valid || !out_stall;
  end

  assign in_stall   = (state != S_IDLE);
  assign walk_start = (state == S_EXEC) && (mode_r == MODE_COPY);

  // the walker owns both memory ports while a copy runs
  always_comb begin
    if (state == S_COPY) begin
      mem_we    = walk_wr_en;
      mem_waddr = walk_wr_addr;
      mem_wdata = mem_rdata;
      mem_re    = walk_rd_en;
      mem_raddr = walk_rd_addr;
    end else begin
      mem_we    = (state == S_EXEC) && (mode_r == MODE_WRITE) && in_range;
      mem_waddr = pix_addr;
      mem_wdata = val_r;
      mem_re    = (state == S_EXEC) && (mode_r == MODE_READ) && in_range;
      mem_raddr = pix_addr;
    end
  end

  crrc_frame_mem #(
    .DEPTH (DEPTH),
    .AW    (AW),
    .DW    (PIXEL_BITS)
  ) u_mem (
    .clk   (clk),
    .we    (mem_we),
    .waddr (mem_waddr),
    .wdata (mem_wdata),
    .re    (mem_re),
    .raddr (mem_raddr),
    .rdata (mem_rdata)
  );

  crrc_copy_walker #(
    .MAX_WIDTH (MAX_WIDTH),
    .AW        (AW)
  ) u_walker (
    .clk     (clk),
    .rst     (rst),
    .start   (walk_start),
    .rect    (rect),
    .used_w  (used_w),
    .used_h  (used_h),
    .rd_en   (walk_rd_en),
    .rd_addr (walk_rd_addr),
    .wr_en   (walk_wr_en),
    .wr_addr (walk_wr_addr),
    .res     (walk_res)
  );

  always_ff @(posedge clk) begin
    if (rst) begin
      image_width       <= RST_IMAGE_SIZE;
      image_height      <= RST_IMAGE_SIZE;
      rect.src_left_x   <= RST_RECT_LO;
      rect.src_top_y    <= RST_RECT_LO;
      rect.src_right_x  <= RST_RECT_HI;
      rect.src_bottom_y <= RST_RECT_HI;
      rect.dest_left_x  <= RST_RECT_LO;
      rect.dest_top_y   <= RST_RECT_LO;
    end else if (cfg_we) begin
      case (cfg_index)
        REG_IMAGE_WIDTH:  image_width       <= cfg_data[SIZE_W-1:0];
        REG_IMAGE_HEIGHT: image_height      <= cfg_data[SIZE_W-1:0];
        REG_SRC_LEFT_X:   rect.src_left_x   <= cfg_data;
        REG_SRC_TOP_Y:    rect.src_top_y    <= cfg_data;
        REG_SRC_RIGHT_X:  rect.src_right_x  <= cfg_data;
        REG_SRC_BOTTOM_Y: rect.src_bottom_y <= cfg_data;
        REG_DEST_LEFT_X:  rect.dest_left_x  <= cfg_data;
        REG_DEST_TOP_Y:   rect.dest_top_y   <= cfg_data;
        default: begin
        end
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state     <= S_IDLE;
      out_valid <= 1'b0;
    end else begin
      // a result leaving while the next one is loaded keeps out_valid high
      if (out_valid && !out_stall && (state != S_RESP)) begin
        out_valid <= 1'b0;
      end
      case (state)
        S_IDLE: begin
          if (accept) begin
            state <= S_EXEC;
          end
        end
        S_EXEC: begin
          if (mode_r == MODE_COPY) begin
            state <= S_COPY;
          end else if ((mode_r == MODE_READ) && in_range) begin
            state <= S_RDWAIT;
          end else begin
            state <= S_RESP;
          end
        end
        S_RDWAIT: begin
          state <= S_RESP;
        end
        S_COPY: begin
          if (walk_res.done) begin
            state <= S_RESP;
          end
        end
        S_RESP: begin
          if (out_free) begin
            out_valid <= 1'b1;
            state     <= S_IDLE;
          end
        end
        default: begin
          state <= S_IDLE;
        end
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (accept) begin
      mode_r <= mode;
      x_r    <= pixel_x;
      y_r    <= pixel_y;
      val_r  <= PIXEL_BITS'(pixel_in);
    end
    case (state)
      S_EXEC: begin
        res_pix <= '0;
        if (((mode_r == MODE_WRITE) || (mode_r == MODE_READ)) && !in_range) begin
          res_stat <= STAT_OUT_OF_FRAME;
        end else begin
          res_stat <= STAT_OK;
        end
      end
      S_RDWAIT: begin
        res_pix <= PIX_IO_W'(mem_rdata);
      end
      S_COPY: begin
        if (walk_res.done) begin
          res_stat <= walk_res.status;
        end
      end
      S_RESP: begin
        if (out_free) begin
          pixel_out <= res_pix;
          status    <= res_stat;
        end
      end
      default: begin
      end
    endcase
  end

  a_walker_only_in_copy: assert property (@(posedge clk) disable iff (rst)
    walk_res.busy |-> (state == S_COPY))
    else $error("copy sequencer active outside a copy");

  a_no_write_when_idle: assert property (@(posedge clk) disable iff (rst)
    ((state == S_IDLE) || (state == S_RESP) || (state == S_RDWAIT)) |-> !mem_we)
    else $error("frame memory written with no write or copy in progress");

  a_result_after_resp: assert property (@(posedge clk) disable iff (rst)
    $rose(out_valid) |-> ($past(state) == S_RESP))
    else $error("result raised without a finished item");

  a_bad_rect_no_walk: assert property (@(posedge clk) disable iff (rst)
    (walk_res.done && (walk_res.status == STAT_BAD_RECT)) |-> !$past(walk_rd_en))
    else $error("invalid rectangle still walked the frame");

endmodule
